/* rtl/tic_pkg.sv */
// Package for the traffic intersection controller: word types, state, codes and phase logic.
package tic_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_SECONDS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PED_EW_SECONDS  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PED_NS_SECONDS  = 8'd3;

    // Register reset values (threshold is 3.5 V on a 5 V, 10-bit converter)
    localparam logic [9:0] LIGHT_THRESHOLD_RST = 10'd717;
    localparam logic [3:0] YELLOW_SECONDS_RST  = 4'd2;
    localparam logic [3:0] PED_EW_SECONDS_RST  = 4'd7;
    localparam logic [3:0] PED_NS_SECONDS_RST  = 4'd8;

    // Green times in seconds
    localparam logic [3:0] EW_GREEN_S       = 4'd6;
    localparam logic [3:0] NSLT_GREEN_DAY_S = 4'd6;
    localparam logic [3:0] NSLT_GREEN_NGT_S = 4'd5;
    localparam logic [3:0] NS_GREEN_DAY_S   = 4'd8;
    localparam logic [3:0] NS_GREEN_NGT_S   = 4'd7;
    localparam logic [3:0] EWLT_GREEN_DAY_S = 4'd8;
    localparam logic [3:0] EWLT_GREEN_NGT_S = 4'd7;
    localparam logic [3:0] FLASH_S          = 4'd1;

    // Longest chain of zero-time phase entries is five; one spare step
    localparam int ENTRY_STEPS = 6;

    typedef enum logic [4:0] {
        P_START       = 5'd0,
        P_EW_PED      = 5'd1,
        P_EW_GREEN    = 5'd2,
        P_EW_YELLOW   = 5'd3,
        P_NSLT_GREEN  = 5'd4,
        P_NSLT_YELLOW = 5'd5,
        P_NS_PED      = 5'd6,
        P_NS_GREEN    = 5'd7,
        P_NS_YELLOW   = 5'd8,
        P_EWLT_GREEN  = 5'd9,
        P_EWLT_YELLOW = 5'd10,
        P_CYCLE_END   = 5'd11,
        P_FLASH_CHECK = 5'd12,
        P_FLASH_RED   = 5'd13,
        P_FLASH_OFF   = 5'd14
    } phase_t;

    typedef enum logic [1:0] {
        C_OFF    = 2'd0,
        C_RED    = 2'd1,
        C_GREEN  = 2'd2,
        C_YELLOW = 2'd3
    } lamp_t;

    typedef struct packed {
        lamp_t ewlt;
        lamp_t ew;
        lamp_t nslt;
        lamp_t ns;
    } lamps_t;

    typedef struct packed {
        logic [9:0] light_threshold;
        logic [3:0] yellow_seconds;
        logic [3:0] ped_ew_seconds;
        logic [3:0] ped_ns_seconds;
    } cfg_t;

    typedef struct packed {
        logic       ped_ns_press;
        logic       ped_ew_press;
        logic       flash_press;
        logic       ns_turn_sensor;
        logic       ew_turn_sensor;
        logic [9:0] light_level;
    } tick_t;

    typedef struct packed {
        logic [1:0] ns_light;
        logic [1:0] ns_turn_light;
        logic [1:0] ew_light;
        logic [1:0] ew_turn_light;
        logic [3:0] phase_count;
        logic [3:0] walk_count;
        logic       second_led;
        logic       buzzer_on;
        logic       day_lamp;
        logic       flashing;
        logic       flash_pending;
    } show_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] seconds_left;
        logic       half_tick;
        logic [3:0] ped_left;
        logic       ped_ns_pending;
        logic       ped_ew_pending;
        logic       flash_latch;
        logic       day_flag;
        logic       light_is_day;
        lamps_t     lamps;
    } state_t;

    // Zero length counts as one second
    function automatic logic [3:0] at_least_one(logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    // One zero-time entry into the current phase: load a duration or move on
    function automatic state_t enter_step(state_t s, logic ns_turn, logic ew_turn, cfg_t c);
        state_t r;
        r = s;
        unique case (s.phase)
            P_EW_PED:
            begin
                if (s.ped_ew_pending)
                begin
                    r.seconds_left = at_least_one(c.ped_ew_seconds);
                    r.ped_left     = r.seconds_left - 4'd1;
                end
                else
                begin
                    r.phase = P_EW_GREEN;
                end
            end
            P_EW_GREEN:
            begin
                r.seconds_left = EW_GREEN_S;
            end
            P_EW_YELLOW:
            begin
                r.lamps.ew     = C_YELLOW;
                r.seconds_left = at_least_one(c.yellow_seconds);
            end
            P_NSLT_GREEN:
            begin
                r.lamps.ew = C_RED;
                if (ns_turn)
                begin
                    r.lamps.nslt   = C_GREEN;
                    r.seconds_left = s.day_flag ? NSLT_GREEN_DAY_S : NSLT_GREEN_NGT_S;
                end
                else
                begin
                    r.phase = P_NS_PED;
                end
            end
            P_NSLT_YELLOW:
            begin
                r.lamps.nslt   = C_YELLOW;
                r.seconds_left = at_least_one(c.yellow_seconds);
            end
            P_NS_PED:
            begin
                r.lamps.nslt = C_RED;
                r.lamps.ns   = C_GREEN;
                if (s.ped_ns_pending)
                begin
                    r.seconds_left = at_least_one(c.ped_ns_seconds);
                    r.ped_left     = r.seconds_left - 4'd1;
                end
                else
                begin
                    r.phase = P_NS_GREEN;
                end
            end
            P_NS_GREEN:
            begin
                r.seconds_left = s.day_flag ? NS_GREEN_DAY_S : NS_GREEN_NGT_S;
            end
            P_NS_YELLOW:
            begin
                r.lamps.ns     = C_YELLOW;
                r.seconds_left = at_least_one(c.yellow_seconds);
            end
            P_EWLT_GREEN:
            begin
                r.lamps.ns = C_RED;
                if (ew_turn)
                begin
                    r.lamps.ewlt   = C_GREEN;
                    r.seconds_left = s.day_flag ? EWLT_GREEN_DAY_S : EWLT_GREEN_NGT_S;
                end
                else
                begin
                    r.phase = P_CYCLE_END;
                end
            end
            P_EWLT_YELLOW:
            begin
                r.lamps.ewlt   = C_YELLOW;
                r.seconds_left = at_least_one(c.yellow_seconds);
            end
            P_CYCLE_END:
            begin
                r.lamps.ewlt = C_RED;
                if (s.flash_latch)
                begin
                    r.flash_latch = 1'b0;
                    r.phase       = P_FLASH_CHECK;
                end
                else
                begin
                    r.phase = P_START;
                end
            end
            P_FLASH_CHECK:
            begin
                if (s.flash_latch)
                begin
                    r.flash_latch = 1'b0;
                    r.phase       = P_START;
                end
                else
                begin
                    r.lamps        = '{C_RED, C_RED, C_RED, C_RED};
                    r.seconds_left = FLASH_S;
                    r.phase        = P_FLASH_RED;
                end
            end
            P_FLASH_RED:
            begin
                r.lamps        = '{C_RED, C_RED, C_RED, C_RED};
                r.seconds_left = FLASH_S;
            end
            P_FLASH_OFF:
            begin
                r.lamps        = '{C_OFF, C_OFF, C_OFF, C_OFF};
                r.seconds_left = FLASH_S;
            end
            // start of cycle: pick day or night from the last light sample
            default:
            begin
                if (!s.light_is_day)
                begin
                    r.ped_ns_pending = 1'b0;
                    r.ped_ew_pending = 1'b0;
                end
                r.day_flag   = s.light_is_day;
                r.lamps.ns   = C_RED;
                r.lamps.nslt = C_RED;
                r.lamps.ew   = C_GREEN;
                r.lamps.ewlt = C_RED;
                r.phase      = P_EW_PED;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/tic_cfg_regs.sv */
// Configuration register file of the traffic intersection controller.
module tic_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tic_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [tic_pkg::CFG_DATA_W-1:0]  wr_data,
    output tic_pkg::cfg_t                   cfg
);
    import tic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Index decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_LIGHT_THRESHOLD: cfg_next.light_threshold = wr_data;
                CFG_YELLOW_SECONDS:  cfg_next.yellow_seconds  = wr_data[3:0];
                CFG_PED_EW_SECONDS:  cfg_next.ped_ew_seconds  = wr_data[3:0];
                CFG_PED_NS_SECONDS:  cfg_next.ped_ns_seconds  = wr_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold <= LIGHT_THRESHOLD_RST;
            cfg_reg.yellow_seconds  <= YELLOW_SECONDS_RST;
            cfg_reg.ped_ew_seconds  <= PED_EW_SECONDS_RST;
            cfg_reg.ped_ns_seconds  <= PED_NS_SECONDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tic_step.sv */
// Next-state and display logic for one half-second tick.
module tic_step (
    input  tic_pkg::state_t state,
    input  tic_pkg::tick_t  tick,
    input  tic_pkg::cfg_t   cfg,
    output tic_pkg::state_t state_next,
    output tic_pkg::show_t  show
);
    import tic_pkg::*;

    state_t s;
    logic   is_ped;
    logic   is_lamp_phase;

    always_comb
    begin
        s = state;

        // Latch button events; pedestrian presses are latched only in day mode
        if (state.day_flag)
        begin
            if (tick.ped_ns_press) s.ped_ns_pending = 1'b1;
            if (tick.ped_ew_press) s.ped_ew_pending = 1'b1;
        end
        if (tick.flash_press) s.flash_latch = 1'b1;

        // Walk through zero-time phase entries at the start of a second
        if (!state.half_tick)
        begin
            for (int i = 0; i < ENTRY_STEPS; i++)
            begin
                if (s.seconds_left == 4'd0)
                    s = enter_step(s, tick.ns_turn_sensor, tick.ew_turn_sensor, cfg);
            end
        end

        is_ped        = (s.phase == P_EW_PED) || (s.phase == P_NS_PED);
        is_lamp_phase = (s.phase >= P_EW_GREEN) && (s.phase <= P_EWLT_YELLOW) && !is_ped;

        // Displayed word
        show.ns_light      = s.lamps.ns;
        show.ns_turn_light = s.lamps.nslt;
        show.ew_light      = s.lamps.ew;
        show.ew_turn_light = s.lamps.ewlt;
        show.phase_count   = is_lamp_phase ? s.seconds_left : 4'd0;
        show.walk_count    = is_ped ? s.ped_left : 4'd0;
        show.second_led    = !s.half_tick;
        show.buzzer_on     = is_ped && !s.half_tick;
        show.day_lamp      = s.day_flag;
        show.flashing      = (s.phase >= P_FLASH_CHECK) && (s.phase <= P_FLASH_OFF);
        show.flash_pending = s.flash_latch;

        // Second end: sample light, count down, advance phase
        if (s.half_tick)
        begin
            s.light_is_day = (tick.light_level < cfg.light_threshold);
            if (is_ped && (s.ped_left != 4'd0)) s.ped_left = s.ped_left - 4'd1;
            if (s.seconds_left != 4'd0) s.seconds_left = s.seconds_left - 4'd1;
            if (s.seconds_left == 4'd0)
            begin
                if (s.phase == P_EW_PED) s.ped_ew_pending = 1'b0;
                if (s.phase == P_NS_PED) s.ped_ns_pending = 1'b0;
                if (s.phase == P_FLASH_OFF)
                    s.phase = P_FLASH_CHECK;
                else if (s.phase < P_FLASH_OFF)
                    s.phase = phase_t'(s.phase + 5'd1);
                else
                    s.phase = P_START;
            end
        end
        s.half_tick = !s.half_tick;

        state_next = s;
    end

endmodule

/* rtl/traffic_intersection_controller_top.sv */
// Top level of the traffic intersection controller: handshake, state and result registers.
//
// Each tick word stands for one half second and yields exactly one status word with the four
// lamp colors, countdowns and mode flags. One word is taken per clock while the result slot is
// free or draining; a word passes the input register, then the result register, where its
// status is presented, and a full result slot that is not taken stalls it in between. The phase
// update for a tick is computed combinationally between those registers. Configuration writes
// are taken in every cycle (cfg_ready is always high); indexes past the last register are
// ignored. The first light cycle after reset runs in night mode.
module traffic_intersection_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_ready,
    input  tic_pkg::tick_t                  tick_word,
    output logic                            show_valid,
    input  logic                            show_ready,
    output tic_pkg::show_t                  show_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tic_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tic_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tic_pkg::*;

    cfg_t   cfg;
    logic   tick_valid_reg;
    tick_t  tick_word_reg;
    state_t state_reg;
    state_t state_next;
    show_t  show_next;
    logic   show_valid_reg;
    show_t  show_word_reg;
    logic   advance;

    assign cfg_ready = 1'b1;

    tic_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the input register moves on whenever the result slot is free or draining
    assign advance    = tick_valid_reg && (!show_valid_reg || show_ready);
    assign tick_ready = !tick_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick_ready)
            tick_valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
            tick_word_reg <= tick_word;
    end

    tic_step u_step (
        .state      (state_reg),
        .tick       (tick_word_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .show       (show_next)
    );

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= P_START;
            state_reg.seconds_left   <= 4'd0;
            state_reg.half_tick      <= 1'b0;
            state_reg.ped_left       <= 4'd0;
            state_reg.ped_ns_pending <= 1'b0;
            state_reg.ped_ew_pending <= 1'b0;
            state_reg.flash_latch    <= 1'b0;
            state_reg.day_flag       <= 1'b0;
            state_reg.light_is_day   <= 1'b0;
            state_reg.lamps          <= '{C_OFF, C_OFF, C_OFF, C_OFF};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            show_valid_reg <= 1'b0;
        else if (advance)
            show_valid_reg <= 1'b1;
        else if (show_ready)
            show_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            show_word_reg <= show_next;
    end

    assign show_valid = show_valid_reg;
    assign show_word  = show_word_reg;

    // Checks
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> show_valid_reg)
        else $error("processed word did not reach the result register");

    a_half_tick_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.half_tick != $past(state_reg.half_tick)))
        else $error("half-second phase did not toggle");

    a_buzzer_first_half: assert property (@(posedge clk) disable iff (!rst_n)
        (show_valid_reg && show_word_reg.buzzer_on) |->
            (show_word_reg.second_led && (show_word_reg.phase_count == 4'd0)))
        else $error("buzzer on outside a countdown first half");

    a_flash_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (show_valid_reg && show_word_reg.flashing) |->
            ((show_word_reg.phase_count == 4'd0) && (show_word_reg.walk_count == 4'd0)))
        else $error("countdown shown while flashing");

endmodule
